### rtl/core/dfr_pkg.sv
// shared types, constants and the byte-wide crc update for the frame deframer
package dfr_pkg;

    localparam int unsigned HDR_DEPTH = 7;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
    localparam logic [15:0] MIN_FRAME = 16'd7;
    localparam logic [15:0] LEN_OVERHEAD = 16'd6;
    localparam logic [16:0] CRC_BYTES = 17'd4;
    localparam logic [16:0] FULL_HDR  = 17'd7;
    localparam logic [15:0] MIN_FETCH = 16'd2;
    localparam logic [15:0] HDR_START = 16'd2;

    // command letters
    localparam logic [7:0] CMD_A = 8'h41;
    localparam logic [7:0] CMD_F = 8'h66;
    localparam logic [7:0] CMD_R = 8'h72;
    localparam logic [7:0] CMD_W = 8'h77;

    // reply flag bytes
    localparam logic [7:0] FLAG_CRC_BAD   = 8'h82;
    localparam logic [7:0] FLAG_BAD_CMD   = 8'h83;
    localparam logic [7:0] FLAG_ZERO_SIZE = 8'h84;
    localparam logic [7:0] FLAG_UNDERRUN  = 8'h80;
    localparam logic [7:0] FLAG_OK_A      = 8'h01;
    localparam logic [7:0] FLAG_OK_FW     = 8'h00;
    localparam logic [7:0] FLAG_OK_R      = 8'h02;

    typedef enum logic [1:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CRC
    } t_phase;

    typedef enum logic [2:0] {
        OUT_ACCEPT    = 3'd0,
        OUT_CRC_BAD   = 3'd1,
        OUT_BAD_CMD   = 3'd2,
        OUT_ZERO_SIZE = 3'd3,
        OUT_UNDERRUN  = 3'd4
    } t_outcome;

    // frame status handed from the parser to the verdict stage
    typedef struct packed {
        logic                           done;
        logic [31:0]                    crc_calc;
        logic [31:0]                    crc_rx;
        logic [HDR_DEPTH-1:0][7:0]      hdr;
        logic [15:0]                    frame_len;
    } t_frame_info;

    // reflected crc-32, one byte, eight bit steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/core/crc32_framed_request_deframer.sv
// top level of the crc-32 framed request deframer
// the verdict for a frame is loaded into the result register when its last crc byte moves on
//   from the input register, and no result is given for any other byte
// throughput: one byte per cycle, with the crc and header updated combinationally in the parser;
//   only a frame's last byte waits in the input register while an earlier verdict is unread
// reset: synchronous active-low i_rst_n; the parser waits for a first length byte, no result
module crc32_framed_request_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [2:0]  o_outcome,
    output logic [7:0]  o_response_flag,
    output logic [7:0]  o_command_char,
    output logic [7:0]  o_can_id,
    output logic [7:0]  o_table_id,
    output logic [15:0] o_table_offset,
    output logic [15:0] o_transfer_size,
    output logic [15:0] o_payload_length
);
    import dfr_pkg::*;

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        out_free;
    logic        advance;
    t_frame_info info;

    // the held byte moves on unless it closes a frame while the result slot is still full
    assign out_free   = !o_res_valid || i_res_ready;
    assign advance    = r_in_vld && (out_free || !info.done);
    assign o_rx_ready = !r_in_vld || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_vld <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    dfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_info    (info)
    );

    dfr_verdict u_verdict (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_info           (info),
        .i_res_ready      (i_res_ready),
        .o_res_valid      (o_res_valid),
        .o_outcome        (o_outcome),
        .o_response_flag  (o_response_flag),
        .o_command_char   (o_command_char),
        .o_can_id         (o_can_id),
        .o_table_id       (o_table_id),
        .o_table_offset   (o_table_offset),
        .o_transfer_size  (o_transfer_size),
        .o_payload_length (o_payload_length)
    );

endmodule

### rtl/core/dfr_parser.sv
// frame parser: length fields, payload crc, header capture and crc byte collection
module dfr_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [7:0]         i_byte,
    output dfr_pkg::t_frame_info o_info
);
    import dfr_pkg::*;

    t_phase                    r_phase, n_phase;
    logic [7:0]                r_first_len, n_first_len;
    logic [15:0]               r_frame_len, n_frame_len;
    logic [15:0]               r_bytes_seen, n_bytes_seen;
    logic [31:0]               r_run_crc, n_run_crc;
    logic [31:0]               r_rx_crc, n_rx_crc;
    logic [HDR_DEPTH-1:0][7:0] r_hdr, n_hdr;

    logic [15:0] len_word;
    logic        len_ok;
    logic [15:0] seen_inc;
    logic        payload_end;
    logic        frame_end;

    assign len_word    = {r_first_len, i_byte};
    assign len_ok      = len_word >= MIN_FRAME;
    assign seen_inc    = r_bytes_seen + 16'd1;
    assign payload_end = ({1'b0, seen_inc} + CRC_BYTES) >= {1'b0, r_frame_len};
    assign frame_end   = (r_phase == PH_CRC) && (seen_inc >= r_frame_len);

    // next phase
    always_comb begin
        unique case (r_phase)
            PH_LEN_HI:  n_phase = PH_LEN_LO;
            PH_LEN_LO:  n_phase = len_ok ? PH_PAYLOAD : PH_LEN_LO;
            PH_PAYLOAD: n_phase = payload_end ? PH_CRC : PH_PAYLOAD;
            PH_CRC:     n_phase = frame_end ? PH_LEN_HI : PH_CRC;
        endcase
    end

    // datapath next values per phase
    always_comb begin
        n_first_len  = r_first_len;
        n_frame_len  = r_frame_len;
        n_bytes_seen = r_bytes_seen;
        n_run_crc    = r_run_crc;
        n_rx_crc     = r_rx_crc;
        n_hdr        = r_hdr;
        unique case (r_phase)
            PH_LEN_HI: begin
                n_first_len = i_byte;
            end
            PH_LEN_LO: begin
                if (len_ok) begin
                    n_frame_len  = len_word;
                    n_bytes_seen = HDR_START;
                    n_run_crc    = CRC_ONES;
                    n_rx_crc     = 32'd0;
                    n_hdr        = '0;
                end else begin
                    n_first_len = i_byte;
                end
            end
            PH_PAYLOAD: begin
                for (int k = 0; k < HDR_DEPTH; k++) begin
                    if (r_bytes_seen == HDR_START + 16'(k)) begin
                        n_hdr[k] = i_byte;
                    end
                end
                n_run_crc    = crc_byte(r_run_crc, i_byte);
                n_bytes_seen = seen_inc;
            end
            PH_CRC: begin
                n_rx_crc     = {r_rx_crc[23:0], i_byte};
                n_bytes_seen = seen_inc;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN_HI;
            r_bytes_seen <= '0;
            r_frame_len  <= '0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_bytes_seen <= n_bytes_seen;
            r_frame_len  <= n_frame_len;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_first_len <= n_first_len;
            r_run_crc   <= n_run_crc;
            r_rx_crc    <= n_rx_crc;
            r_hdr       <= n_hdr;
        end
    end

    // status for the verdict stage, valid with the current byte
    always_comb begin
        o_info.done      = frame_end;
        o_info.crc_calc  = r_run_crc ^ CRC_ONES;
        o_info.crc_rx    = n_rx_crc;
        o_info.hdr       = r_hdr;
        o_info.frame_len = r_frame_len;
    end

endmodule

### rtl/core/dfr_verdict.sv
// request decode and the result register
module dfr_verdict (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  dfr_pkg::t_frame_info i_info,
    input  logic                 i_res_ready,
    output logic                 o_res_valid,
    output logic [2:0]           o_outcome,
    output logic [7:0]           o_response_flag,
    output logic [7:0]           o_command_char,
    output logic [7:0]           o_can_id,
    output logic [7:0]           o_table_id,
    output logic [15:0]          o_table_offset,
    output logic [15:0]          o_transfer_size,
    output logic [15:0]          o_payload_length
);
    import dfr_pkg::*;

    logic        r_valid;
    t_outcome    r_outcome, n_outcome;
    logic [7:0]  r_flag, n_flag;
    logic [7:0]  r_cmd, r_can, r_tab;
    logic [15:0] r_ofs, r_size, r_plen;

    logic [7:0]  cmd;
    logic [15:0] size;
    logic [15:0] plen;
    logic        short_hdr;

    assign cmd       = i_info.hdr[0];
    assign size      = {i_info.hdr[5], i_info.hdr[6]};
    assign plen      = i_info.frame_len - LEN_OVERHEAD;
    assign short_hdr = {1'b0, plen} < FULL_HDR;

    // decode, crc check first
    always_comb begin
        n_outcome = OUT_ACCEPT;
        n_flag    = FLAG_OK_FW;
        priority if (i_info.crc_calc != i_info.crc_rx) begin
            n_outcome = OUT_CRC_BAD;
            n_flag    = FLAG_CRC_BAD;
        end else if (cmd == CMD_A) begin
            n_outcome = OUT_ACCEPT;
            n_flag    = FLAG_OK_A;
        end else if (cmd == CMD_F) begin
            if (plen < MIN_FETCH) begin
                n_outcome = OUT_BAD_CMD;
                n_flag    = FLAG_BAD_CMD;
            end
        end else if (cmd == CMD_R) begin
            if (short_hdr) begin
                n_outcome = OUT_BAD_CMD;
                n_flag    = FLAG_BAD_CMD;
            end else if (size == 16'd0) begin
                n_outcome = OUT_ZERO_SIZE;
                n_flag    = FLAG_ZERO_SIZE;
            end else begin
                n_flag    = FLAG_OK_R;
            end
        end else if (cmd == CMD_W) begin
            if (short_hdr) begin
                n_outcome = OUT_BAD_CMD;
                n_flag    = FLAG_BAD_CMD;
            end else if ({1'b0, plen} < FULL_HDR + {1'b0, size}) begin
                n_outcome = OUT_UNDERRUN;
                n_flag    = FLAG_UNDERRUN;
            end
        end else begin
            n_outcome = OUT_BAD_CMD;
            n_flag    = FLAG_BAD_CMD;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance && i_info.done) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_advance && i_info.done) begin
            r_outcome <= n_outcome;
            r_flag    <= n_flag;
            r_cmd     <= cmd;
            r_can     <= i_info.hdr[1];
            r_tab     <= i_info.hdr[2];
            r_ofs     <= {i_info.hdr[3], i_info.hdr[4]};
            r_size    <= size;
            r_plen    <= plen;
        end
    end

    assign o_res_valid      = r_valid;
    assign o_outcome        = r_outcome;
    assign o_response_flag  = r_flag;
    assign o_command_char   = r_cmd;
    assign o_can_id         = r_can;
    assign o_table_id       = r_tab;
    assign o_table_offset   = r_ofs;
    assign o_transfer_size  = r_size;
    assign o_payload_length = r_plen;

endmodule

### rtl/core/dfr_checker.sv
// port-level checks for the deframer and their bind to the top level
module dfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_rx_ready,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic [2:0]  o_outcome,
    input logic [7:0]  o_response_flag,
    input logic [15:0] o_payload_length
);
    import dfr_pkg::*;

    // no result straight after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // an empty result slot never blocks the request side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res_valid |-> o_rx_ready)
        else $error("request side stalled with empty result slot");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_outcome)
            && $stable(o_response_flag))
        else $error("stalled result changed");

    // flag agrees with the outcome code
    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |->
            (o_outcome == OUT_CRC_BAD   && o_response_flag == FLAG_CRC_BAD)   ||
            (o_outcome == OUT_BAD_CMD   && o_response_flag == FLAG_BAD_CMD)   ||
            (o_outcome == OUT_ZERO_SIZE && o_response_flag == FLAG_ZERO_SIZE) ||
            (o_outcome == OUT_UNDERRUN  && o_response_flag == FLAG_UNDERRUN)  ||
            (o_outcome == OUT_ACCEPT    && (o_response_flag == FLAG_OK_A ||
                o_response_flag == FLAG_OK_FW || o_response_flag == FLAG_OK_R)))
        else $error("flag does not match outcome");

    // a frame always carries at least one payload byte
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_payload_length != 16'd0)
        else $error("empty payload reported");

endmodule

bind crc32_framed_request_deframer dfr_checker u_dfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_rx_ready       (o_rx_ready),
    .o_res_valid      (o_res_valid),
    .i_res_ready      (i_res_ready),
    .o_outcome        (o_outcome),
    .o_response_flag  (o_response_flag),
    .o_payload_length (o_payload_length)
);

### tb/tb.sv
// self-checking testbench for the crc-32 framed request deframer
`timescale 1ns / 100ps

module tb;
    import dfr_pkg::*;

    localparam int IDLE_LIMIT   = 600;
    localparam int LONG_PAYLOAD = 48;

    // one predicted verdict for a completed frame
    typedef struct {
        t_outcome    outcome;
        logic [7:0]  flag;
        logic [7:0]  cmd;
        logic [7:0]  can_id;
        logic [7:0]  table_id;
        logic [15:0] offset;
        logic [15:0] size;
        logic [15:0] plen;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_rx_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_res_ready = 1'b0;
    logic        o_rx_ready;
    logic        o_res_valid;
    logic [2:0]  o_outcome;
    logic [7:0]  o_response_flag;
    logic [7:0]  o_command_char;
    logic [7:0]  o_can_id;
    logic [7:0]  o_table_id;
    logic [15:0] o_table_offset;
    logic [15:0] o_transfer_size;
    logic [15:0] o_payload_length;

    // predicted parser state
    t_phase      rx_phase  = PH_LEN_HI;
    logic [7:0]  held_len  = 8'h00;
    logic [15:0] frame_len = 16'h0000;
    logic [15:0] seen      = 16'h0000;
    logic [31:0] crc_run   = CRC_ONES;
    logic [31:0] crc_rx    = 32'h0000_0000;
    logic [7:0]  hdr_cap [HDR_DEPTH] = '{default: 8'h00};

    t_verdict    verdict_q [$];
    logic [7:0]  body [$];
    int          fail_count    = 0;
    int          idle_cycles   = 0;
    int          bytes_sent    = 0;
    int          ready_hold    = 0;
    bit          steady        = 1'b0;

    crc32_framed_request_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_outcome        (o_outcome),
        .o_response_flag  (o_response_flag),
        .o_command_char   (o_command_char),
        .o_can_id         (o_can_id),
        .o_table_id       (o_table_id),
        .o_table_offset   (o_table_offset),
        .o_transfer_size  (o_transfer_size),
        .o_payload_length (o_payload_length)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // reflected crc-32 over one byte, lsb first
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else c = c >> 1;
        end
        return c;
    endfunction

    // crc check first, then command decode on the captured header
    function automatic t_verdict frame_verdict();
        t_verdict v;
        int plen;
        int size;
        plen = int'(frame_len) - 6;
        size = int'({hdr_cap[5], hdr_cap[6]});
        v.outcome = OUT_ACCEPT;
        v.flag = FLAG_OK_FW;
        if ((crc_run ^ CRC_ONES) != crc_rx) begin
            v.outcome = OUT_CRC_BAD;
            v.flag = FLAG_CRC_BAD;
        end else if (hdr_cap[0] == CMD_A) begin
            v.flag = FLAG_OK_A;
        end else if (hdr_cap[0] == CMD_F) begin
            if (plen < 2) begin
                v.outcome = OUT_BAD_CMD;
                v.flag = FLAG_BAD_CMD;
            end
        end else if (hdr_cap[0] == CMD_R) begin
            if (plen < 7) begin
                v.outcome = OUT_BAD_CMD;
                v.flag = FLAG_BAD_CMD;
            end else if (size == 0) begin
                v.outcome = OUT_ZERO_SIZE;
                v.flag = FLAG_ZERO_SIZE;
            end else begin
                v.flag = FLAG_OK_R;
            end
        end else if (hdr_cap[0] == CMD_W) begin
            if (plen < 7) begin
                v.outcome = OUT_BAD_CMD;
                v.flag = FLAG_BAD_CMD;
            end else if (plen < 7 + size) begin
                v.outcome = OUT_UNDERRUN;
                v.flag = FLAG_UNDERRUN;
            end
        end else begin
            v.outcome = OUT_BAD_CMD;
            v.flag = FLAG_BAD_CMD;
        end
        v.cmd = hdr_cap[0];
        v.can_id = hdr_cap[1];
        v.table_id = hdr_cap[2];
        v.offset = {hdr_cap[3], hdr_cap[4]};
        v.size = size[15:0];
        v.plen = plen[15:0];
        return v;
    endfunction

    // advance the predicted parser by one accepted byte
    task automatic predict_byte(input logic [7:0] b);
        logic [15:0] len;
        case (rx_phase)
            PH_LEN_LO: begin
                len = {held_len, b};
                if (len < MIN_FRAME) begin
                    held_len = b;
                end else begin
                    frame_len = len;
                    seen = 16'd2;
                    crc_run = CRC_ONES;
                    crc_rx = 32'h0000_0000;
                    foreach (hdr_cap[i]) hdr_cap[i] = 8'h00;
                    rx_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (int'(seen) - 2 < HDR_DEPTH) hdr_cap[int'(seen) - 2] = b;
                crc_run = crc32_step(crc_run, b);
                seen = seen + 16'd1;
                if ({1'b0, seen} + 17'd4 >= {1'b0, frame_len}) rx_phase = PH_CRC;
            end
            PH_CRC: begin
                crc_rx = {crc_rx[23:0], b};
                seen = seen + 16'd1;
                if (seen >= frame_len) begin
                    rx_phase = PH_LEN_HI;
                    verdict_q.insert(verdict_q.size(), frame_verdict());
                end
            end
            default: begin
                held_len = b;
                rx_phase = PH_LEN_LO;
            end
        endcase
    endtask

    // offer one request byte, with an optional random gap first
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            @(negedge i_clk);
            i_rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        bytes_sent++;
        predict_byte(b);
    endtask

    task automatic lower_valid();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // filler until the parser is back at a length byte
    task automatic resync_parser();
        while (!(rx_phase == PH_LEN_HI || (rx_phase == PH_LEN_LO && held_len == 8'h00)))
            send_byte(8'($urandom));
    endtask

    // payload with a given command, size and length, other bytes random
    task automatic make_body(input logic [7:0] cmd, input int plen, input logic [15:0] size);
        logic [7:0] hdr [HDR_DEPTH];
        hdr[0] = cmd;
        hdr[1] = 8'($urandom);
        hdr[2] = 8'($urandom);
        {hdr[3], hdr[4]} = 16'($urandom);
        {hdr[5], hdr[6]} = size;
        body.delete();
        for (int i = 0; i < plen; i++)
            body.insert(body.size(), i < HDR_DEPTH ? hdr[i] : 8'($urandom));
    endtask

    // frame the current body; a non-zero declared length overrides the true one
    task automatic send_frame(input int declared, input bit corrupt);
        logic [15:0] flen;
        logic [31:0] crc;
        logic [7:0]  wire_q [$];
        int          stop;
        flen = 16'(body.size() + 6);
        if (declared != 0) flen = 16'(declared);
        crc = CRC_ONES;
        foreach (body[i]) crc = crc32_step(crc, body[i]);
        crc = crc ^ CRC_ONES;
        if (corrupt) crc = crc ^ (32'h1 << $urandom_range(0, 31));
        wire_q.insert(wire_q.size(), flen[15:8]);
        wire_q.insert(wire_q.size(), flen[7:0]);
        foreach (body[i]) wire_q.insert(wire_q.size(), body[i]);
        for (int i = 3; i >= 0; i--) wire_q.insert(wire_q.size(), crc[8*i +: 8]);
        stop = (declared != 0 && declared < wire_q.size()) ? declared : wire_q.size();
        for (int i = 0; i < stop; i++) send_byte(wire_q[i]);
        resync_parser();
    endtask

    // mostly well-formed requests, some with zero padding, bad lengths or bad crc
    task automatic random_frame();
        int         pick;
        int         plen;
        int         declared;
        logic [7:0] cmd;
        logic [15:0] size;
        bit         corrupt;
        pick = $urandom_range(0, 99);
        size = 16'($urandom);
        declared = 0;
        corrupt = 1'b0;
        case ($urandom_range(0, 4))
            0: begin
                cmd = CMD_A;
                plen = $urandom_range(1, 12);
            end
            1: begin
                cmd = CMD_F;
                plen = $urandom_range(1, 12);
            end
            2: begin
                cmd = CMD_R;
                plen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 14);
                if ($urandom_range(0, 3) == 0) size = 16'h0000;
            end
            3: begin
                cmd = CMD_W;
                case ($urandom_range(0, 3))
                    0: plen = $urandom_range(1, 6);
                    1: begin
                        size = 16'($urandom_range(1, 40));
                        plen = 7 + $urandom_range(0, int'(size) - 1);
                    end
                    2: plen = $urandom_range(7, 14);
                    default: begin
                        size = 16'($urandom_range(0, 20));
                        plen = 7 + int'(size) + $urandom_range(0, 3);
                    end
                endcase
            end
            default: begin
                cmd = 8'($urandom);
                plen = $urandom_range(1, 12);
            end
        endcase
        make_body(cmd, plen, size);
        if (pick < 8) repeat ($urandom_range(1, 4)) send_byte(8'h00);
        else if (pick < 16) declared = $urandom_range(7, plen + 14);
        else if (pick < 24) corrupt = 1'b1;
        send_frame(declared, corrupt);
    endtask

    // zero lengths are dropped until a usable length arrives
    task automatic test_short_length_resync();
        repeat (3) send_byte(8'h00);
        make_body(CMD_A, 1, 16'h0000);
        send_frame(0, 1'b0);
    endtask

    // fetch with only the command byte
    task automatic test_short_fetch();
        make_body(CMD_F, 1, 16'h0000);
        send_frame(0, 1'b0);
    endtask

    // all-ones header with a broken crc
    task automatic test_crc_mismatch_ones();
        body.delete();
        repeat (HDR_DEPTH) body.insert(body.size(), 8'hFF);
        send_frame(0, 1'b1);
    endtask

    task automatic test_random_frames(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) random_frame();
    endtask

    // sender holds off until every verdict is out
    task automatic test_pause_until_drained();
        lower_valid();
        wait_drained();
    endtask

    // long payload, a write that exactly fits its size
    task automatic test_long_frame();
        make_body(CMD_W, LONG_PAYLOAD, 16'(LONG_PAYLOAD - 7));
        send_frame(0, 1'b0);
    endtask

    task automatic test_steady_tail();
        steady = 1'b1;
        test_random_frames(100);
    endtask

    function automatic void check_field(input string name, input logic [15:0] expv,
                                        input logic [15:0] act);
        if (act !== expv) begin
            $error("%s expected 0x%0h actual 0x%0h", name, expv, act);
            fail_count++;
        end
    endfunction

    // result side stalls in random bursts
    always @(negedge i_clk) begin
        if (steady) begin
            i_res_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_res_ready <= 1'b0;
            ready_hold = $urandom_range(0, 13);
        end else begin
            i_res_ready <= 1'b1;
            ready_hold = $urandom_range(0, 24);
        end
    end

    // compare each verdict with the oldest prediction, count idle cycles
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (o_res_valid && i_res_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict with none predicted");
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("outcome", 16'(want.outcome), 16'(o_outcome));
                    check_field("response_flag", 16'(want.flag), 16'(o_response_flag));
                    check_field("command_char", 16'(want.cmd), 16'(o_command_char));
                    check_field("can_id", 16'(want.can_id), 16'(o_can_id));
                    check_field("table_id", 16'(want.table_id), 16'(o_table_id));
                    check_field("table_offset", want.offset, o_table_offset);
                    check_field("transfer_size", want.size, o_transfer_size);
                    check_field("payload_length", want.plen, o_payload_length);
                end
            end
            if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // watchdog on a stalled handshake
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // test sequence
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_length_resync();
        test_short_fetch();
        test_crc_mismatch_ones();
        test_random_frames(330);
        test_pause_until_drained();
        test_random_frames(200);
        test_long_frame();
        test_steady_tail();
        lower_valid();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
